[src/ihex_pkg.sv]
`timescale 1ns / 1ps

package ihex_pkg;

   // parse phases of one record
   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_COUNT = 3'd1,
      PH_OFSHI = 3'd2,
      PH_OFSLO = 3'd3,
      PH_TYPE  = 3'd4,
      PH_DATA  = 3'd5,
      PH_CSUM  = 3'd6,
      PH_HALT  = 3'd7
   } phase_type;

   // event codes on the response channel
   localparam logic [2:0] EV_WRITE     = 3'd0;
   localparam logic [2:0] EV_RECORD_OK = 3'd1;
   localparam logic [2:0] EV_EOF       = 3'd2;
   localparam logic [2:0] EV_BAD_COUNT = 3'd3;
   localparam logic [2:0] EV_CSUM_ERR  = 3'd4;

   // record types
   localparam logic [7:0] RT_DATA = 8'h00;
   localparam logic [7:0] RT_EOF  = 8'h01;
   localparam logic [7:0] RT_ESA  = 8'h02;
   localparam logic [7:0] RT_SSA  = 8'h03;
   localparam logic [7:0] RT_ELA  = 8'h04;
   localparam logic [7:0] RT_SLA  = 8'h05;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] UPPER_LIMIT_RESET = 8'h05;

   // one parser result
   typedef struct packed {
      logic        valid;
      logic [2:0]  event_res;
      logic [23:0] address;
      logic [7:0]  data_byte;
      logic [23:0] highest_address;
   } result_type;

   // hex digit decode: bit 4 set means the character is no hex digit
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b0, 4'(c - 8'h37)};
      end
      return d;
   endfunction

endpackage

[src/ihex_core.sv]
`timescale 1ns / 1ps

module ihex_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            character,
   input  logic [7:0]            upper_limit,
   output ihex_pkg::result_type  result
);

   ihex_pkg::phase_type phase_ff, phase_in;
   logic        second_due_ff, second_due_in;
   logic [3:0]  high_digit_ff, high_digit_in;
   logic        high_valid_ff, high_valid_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [16:0] offset_ff, offset_in;
   logic [15:0] upper_ff, upper_in;
   logic [7:0]  rec_type_ff, rec_type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [23:0] highest_ff, highest_in;
   logic [1:0]  seg_idx_ff, seg_idx_in;

   logic [4:0]  dig;
   logic        dig_ok;
   logic        pair_ok;
   logic [7:0]  val;
   logic [7:0]  sum_next;
   logic [7:0]  bytes_dec;
   logic [23:0] addr;
   logic        do_write;
   logic        is_colon;

   // pair decode
   assign dig      = ihex_pkg::digit_value(character);
   assign dig_ok   = ~dig[4];
   assign pair_ok  = high_valid_ff & dig_ok;
   assign val      = pair_ok ? {high_digit_ff, dig[3:0]} : 8'h00;
   assign sum_next = sum_ff + val;
   assign bytes_dec = bytes_left_ff - 8'd1;
   assign is_colon = (character == ihex_pkg::CHAR_COLON);
   assign addr     = {upper_ff[7:0], 16'h0000} + {7'd0, offset_ff};
   assign do_write = (rec_type_ff == ihex_pkg::RT_DATA) &&
                     (upper_ff <= {8'h00, upper_limit});

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (phase_ff == ihex_pkg::PH_WAIT) begin
            if (is_colon) phase_in = ihex_pkg::PH_COUNT;
         end else if (phase_ff != ihex_pkg::PH_HALT && second_due_ff) begin
            unique case (phase_ff)
               ihex_pkg::PH_COUNT: begin
                  phase_in = pair_ok ? ihex_pkg::PH_OFSHI : ihex_pkg::PH_HALT;
               end
               ihex_pkg::PH_OFSHI: phase_in = ihex_pkg::PH_OFSLO;
               ihex_pkg::PH_OFSLO: phase_in = ihex_pkg::PH_TYPE;
               ihex_pkg::PH_TYPE: begin
                  case (val) inside
                     ihex_pkg::RT_DATA, ihex_pkg::RT_ESA,
                     ihex_pkg::RT_SSA, ihex_pkg::RT_SLA: begin
                        phase_in = (bytes_left_ff != 8'd0) ? ihex_pkg::PH_DATA
                                                           : ihex_pkg::PH_CSUM;
                     end
                     ihex_pkg::RT_ELA: phase_in = ihex_pkg::PH_DATA;
                     default:          phase_in = ihex_pkg::PH_CSUM;
                  endcase
               end
               ihex_pkg::PH_DATA: begin
                  if (bytes_dec == 8'd0) phase_in = ihex_pkg::PH_CSUM;
               end
               ihex_pkg::PH_CSUM: begin
                  if (sum_next != 8'd0 || rec_type_ff == ihex_pkg::RT_EOF) begin
                     phase_in = ihex_pkg::PH_HALT;
                  end else begin
                     phase_in = ihex_pkg::PH_WAIT;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // datapath state and result
   always_comb begin
      second_due_in = second_due_ff;
      high_digit_in = high_digit_ff;
      high_valid_in = high_valid_ff;
      bytes_left_in = bytes_left_ff;
      offset_in     = offset_ff;
      upper_in      = upper_ff;
      rec_type_in   = rec_type_ff;
      sum_in        = sum_ff;
      highest_in    = highest_ff;
      seg_idx_in    = seg_idx_ff;
      result        = '0;
      result.highest_address = highest_ff;
      if (step && phase_ff != ihex_pkg::PH_HALT) begin
         if (phase_ff == ihex_pkg::PH_WAIT) begin
            if (is_colon) begin
               second_due_in = 1'b0;
               sum_in        = 8'd0;
            end
         end else if (!second_due_ff) begin
            // first digit of a pair
            high_digit_in = dig[3:0];
            high_valid_in = dig_ok;
            second_due_in = 1'b1;
         end else begin
            second_due_in = 1'b0;
            sum_in        = sum_next;
            unique case (phase_ff)
               ihex_pkg::PH_COUNT: begin
                  if (!pair_ok) begin
                     result.valid     = 1'b1;
                     result.event_res = ihex_pkg::EV_BAD_COUNT;
                  end else begin
                     bytes_left_in = val;
                  end
               end
               ihex_pkg::PH_OFSHI: offset_in = {1'b0, val, 8'h00};
               ihex_pkg::PH_OFSLO: offset_in = {offset_ff[16:8], val};
               ihex_pkg::PH_TYPE: begin
                  rec_type_in = val;
                  if (val == ihex_pkg::RT_ELA) begin
                     bytes_left_in = 8'd2;
                     seg_idx_in    = 2'd0;
                  end
               end
               ihex_pkg::PH_DATA: begin
                  bytes_left_in = bytes_dec;
                  if (rec_type_ff == ihex_pkg::RT_ELA) begin
                     // upper segment, high byte first
                     if (seg_idx_ff == 2'd0) upper_in = {val, 8'h00};
                     else                    upper_in = upper_ff | {8'h00, val};
                     seg_idx_in = seg_idx_ff + 2'd1;
                  end else if (do_write) begin
                     if (addr > highest_ff) highest_in = addr;
                     offset_in = offset_ff + 17'd1;
                     result.valid           = 1'b1;
                     result.event_res       = ihex_pkg::EV_WRITE;
                     result.address         = addr;
                     result.data_byte       = val;
                     result.highest_address = (addr > highest_ff) ? addr : highest_ff;
                  end
               end
               ihex_pkg::PH_CSUM: begin
                  result.valid = 1'b1;
                  if (sum_next != 8'd0) begin
                     result.event_res = ihex_pkg::EV_CSUM_ERR;
                  end else if (rec_type_ff == ihex_pkg::RT_EOF) begin
                     result.event_res = ihex_pkg::EV_EOF;
                  end else begin
                     result.event_res = ihex_pkg::EV_RECORD_OK;
                  end
               end
               default: result.valid = 1'b0;
            endcase
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ihex_pkg::PH_WAIT;
         second_due_ff <= 1'b0;
         high_digit_ff <= 4'd0;
         high_valid_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         offset_ff     <= 17'd0;
         upper_ff      <= 16'd0;
         rec_type_ff   <= 8'd0;
         sum_ff        <= 8'd0;
         highest_ff    <= 24'd0;
         seg_idx_ff    <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         second_due_ff <= second_due_in;
         high_digit_ff <= high_digit_in;
         high_valid_ff <= high_valid_in;
         bytes_left_ff <= bytes_left_in;
         offset_ff     <= offset_in;
         upper_ff      <= upper_in;
         rec_type_ff   <= rec_type_in;
         sum_ff        <= sum_in;
         highest_ff    <= highest_in;
         seg_idx_ff    <= seg_idx_in;
      end
   end

endmodule

[src/intel_hex_record_parser.sv]
`timescale 1ns / 1ps

// Intel HEX (I32HEX) record parser. One text character enters per request and
// moves through an input register into the parse logic, which updates the record
// state and loads at most one response into the output register; a character is
// held in the input register and its response in the output register, and one
// character per cycle is sustained while rsp_ready stays high. The output
// register is only refilled when empty or being drained, so a stalled response
// holds at most one more character in the input register. Responses are data
// writes (type 0 records whose upper segment is at most csr upper_limit), record
// ok, end of file, bad count digit and checksum error; after either kind of
// error or end of file the parser ignores all input until reset.
module intel_hex_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [23:0] rsp_address,
   output logic [7:0]  rsp_data_byte,
   output logic [23:0] rsp_highest_address,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           char_ff;
   logic [7:0]           limit_ff;
   logic                 advance;
   ihex_pkg::result_type result;
   ihex_pkg::result_type rsp_ff;
   logic                 rsp_valid_in;

   // advance when the output register is free or being taken
   assign advance   = in_valid_ff & (~rsp_ff.valid | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_ff.valid;
      if (advance)        rsp_valid_in = result.valid;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ihex_pkg::UPPER_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) char_ff <= req_character;
   end

   ihex_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .character   (char_ff),
      .upper_limit (limit_ff),
      .result      (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_valid_in;
      end
      if (advance && result.valid) begin
         rsp_ff.event_res       <= result.event_res;
         rsp_ff.address         <= result.address;
         rsp_ff.data_byte       <= result.data_byte;
         rsp_ff.highest_address <= result.highest_address;
      end
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_event_res       = rsp_ff.event_res;
   assign rsp_address         = rsp_ff.address;
   assign rsp_data_byte       = rsp_ff.data_byte;
   assign rsp_highest_address = rsp_ff.highest_address;

endmodule
